### sv/chav_pkg.sv
`default_nettype none

package chav_pkg;

  // Default build parameters.
  localparam int unsigned SAMPLES_DEF      = 8;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_LEN         = 24;

  // Field and register widths.
  localparam int unsigned RAWW  = 16;
  localparam int unsigned OFFW  = 12;
  localparam int unsigned GAINW = 16;
  localparam int unsigned MAGW  = 16;
  localparam int unsigned SW    = 17;
  localparam int unsigned FRACW = 16;
  localparam int unsigned CW    = 35;
  localparam int unsigned ZW    = 26;
  localparam int unsigned DW    = 9;
  localparam int unsigned SUMW  = 15;
  localparam int unsigned MEANW = 9;
  localparam int unsigned HALFW = 8;
  localparam int unsigned IDXW  = 2;
  localparam int unsigned CFGW  = 16;

  // Queue between the front and the back.
  localparam int unsigned QDEPTH = 4;

  // Register reset values.
  localparam logic signed [OFFW-1:0] X_OFF_RST = 12'sd15;
  localparam logic signed [OFFW-1:0] Y_OFF_RST = 12'sd85;
  localparam logic [GAINW-1:0]       GAIN_RST  = 16'd60293;

  // Angles in degrees with 16 fraction bits.
  localparam logic signed [ZW-1:0] ZHALF     = 26'sd11796480;
  localparam logic signed [ZW-1:0] ZFULL     = 26'sd23592960;
  localparam logic [DW-1:0]        FULL_TURN = 9'd360;

  typedef enum logic [IDXW-1:0] {
    REG_X_OFFSET  = 2'd0,
    REG_Y_OFFSET  = 2'd1,
    REG_AXIS_GAIN = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
  } axis_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_deg(input int unsigned i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:  a = 26'sd2949120;
      1:  a = 26'sd1740967;
      2:  a = 26'sd919879;
      3:  a = 26'sd466945;
      4:  a = 26'sd234379;
      5:  a = 26'sd117304;
      6:  a = 26'sd58666;
      7:  a = 26'sd29335;
      8:  a = 26'sd14668;
      9:  a = 26'sd7334;
      10: a = 26'sd3667;
      11: a = 26'sd1833;
      12: a = 26'sd917;
      13: a = 26'sd458;
      14: a = 26'sd229;
      15: a = 26'sd115;
      16: a = 26'sd57;
      17: a = 26'sd29;
      18: a = 26'sd14;
      19: a = 26'sd7;
      20: a = 26'sd4;
      21: a = 26'sd2;
      22: a = 26'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### sv/chav_front.sv
`default_nettype none

module chav_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [chav_pkg::IDXW-1:0]           cfg_idx_i,
  input  wire logic [chav_pkg::CFGW-1:0]           cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [chav_pkg::RAWW-1:0]    x_raw_i,
  input  wire logic signed [chav_pkg::RAWW-1:0]    y_raw_i,
  input  wire chav_pkg::q_status_t                 q_status_i,
  output logic                                     push_o,
  output chav_pkg::axis_t                          push_data_o
);

  logic signed [chav_pkg::OFFW-1:0] x_off_q, y_off_q;
  logic [chav_pkg::GAINW-1:0]       gain_q;

  logic                         s1_vld_q, s2_vld_q;
  logic                         s1_xneg_q, s1_yneg_q, s2_xneg_q, s2_yneg_q;
  logic [chav_pkg::MAGW-1:0]    s1_xmag_q, s1_ymag_q, s2_xmag_q, s2_ymag_q;

  logic [chav_pkg::SW-1:0]      xsum, ysum, xabs, yabs;
  logic [2*chav_pkg::MAGW-1:0]  xprod, yprod;
  logic                         discard, adv, s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q <= chav_pkg::X_OFF_RST;
      y_off_q <= chav_pkg::Y_OFF_RST;
      gain_q  <= chav_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (chav_pkg::cfg_reg_e'(cfg_idx_i))
        chav_pkg::REG_X_OFFSET:  x_off_q <= cfg_wdata_i[chav_pkg::OFFW-1:0];
        chav_pkg::REG_Y_OFFSET:  y_off_q <= cfg_wdata_i[chav_pkg::OFFW-1:0];
        chav_pkg::REG_AXIS_GAIN: gain_q  <= cfg_wdata_i[chav_pkg::GAINW-1:0];
        default: ;
      endcase
    end
  end

  // Offset add and magnitude; the sum always fits in 16 magnitude bits.
  assign xsum = {x_raw_i[chav_pkg::RAWW-1], x_raw_i}
              + {{(chav_pkg::SW-chav_pkg::OFFW){x_off_q[chav_pkg::OFFW-1]}}, x_off_q};
  assign ysum = {y_raw_i[chav_pkg::RAWW-1], y_raw_i}
              + {{(chav_pkg::SW-chav_pkg::OFFW){y_off_q[chav_pkg::OFFW-1]}}, y_off_q};
  assign xabs = xsum[chav_pkg::SW-1] ? (chav_pkg::SW'(0) - xsum) : xsum;
  assign yabs = ysum[chav_pkg::SW-1] ? (chav_pkg::SW'(0) - ysum) : ysum;

  // Gain multiply, truncating the magnitude toward zero.
  assign xprod = {{chav_pkg::MAGW{1'b0}}, s1_xmag_q} * {{chav_pkg::MAGW{1'b0}}, gain_q};
  assign yprod = {{chav_pkg::MAGW{1'b0}}, s1_ymag_q} * {{chav_pkg::MAGW{1'b0}}, gain_q};

  // A sample whose scaled X is zero leaves the pipeline without a push.
  assign discard    = (s2_xmag_q == '0);
  assign adv        = !s2_vld_q || discard || !q_status_i.full;
  assign s1_en      = !s1_vld_q || adv;
  assign in_ready_o = s1_en;
  assign push_o     = s2_vld_q && !discard && !q_status_i.full;

  assign push_data_o.sx = s2_xneg_q ? (chav_pkg::SW'(0) - {1'b0, s2_xmag_q})
                                    : {1'b0, s2_xmag_q};
  assign push_data_o.sy = s2_yneg_q ? (chav_pkg::SW'(0) - {1'b0, s2_ymag_q})
                                    : {1'b0, s2_ymag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_vld_q <= in_valid_i;
      end
      if (adv) begin
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_xneg_q <= xsum[chav_pkg::SW-1];
      s1_yneg_q <= ysum[chav_pkg::SW-1];
      s1_xmag_q <= xabs[chav_pkg::MAGW-1:0];
      s1_ymag_q <= yabs[chav_pkg::MAGW-1:0];
    end
    if (adv) begin
      s2_xneg_q <= s1_xneg_q;
      s2_yneg_q <= s1_yneg_q;
      s2_xmag_q <= xprod[2*chav_pkg::MAGW-1:chav_pkg::MAGW];
      s2_ymag_q <= yprod[2*chav_pkg::MAGW-1:chav_pkg::MAGW];
    end
  end

endmodule

`default_nettype wire

### sv/chav_fifo.sv
`default_nettype none

module chav_fifo #(
  parameter int unsigned DEPTH = chav_pkg::QDEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire chav_pkg::axis_t     push_data_i,
  input  wire logic                pop_i,
  output chav_pkg::axis_t          pop_data_o,
  output chav_pkg::q_status_t      status_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);

  chav_pkg::axis_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [LW-1:0]   level_q;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign pop_data_o      = mem_q[rd_ptr_q];
  assign status_o.full   = (level_q == LW'(DEPTH));
  assign status_o.empty  = (level_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + LW'(1);
      end else if (pop_i && !push_i) begin
        level_q <= level_q - LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### sv/chav_back.sv
`default_nettype none

module chav_back #(
  parameter int unsigned SAMPLES      = chav_pkg::SAMPLES_DEF,
  parameter int unsigned CORDIC_STEPS = chav_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire chav_pkg::q_status_t          q_status_i,
  input  wire chav_pkg::axis_t              pop_data_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [chav_pkg::MEANW-1:0]        heading_mean_o,
  output logic [chav_pkg::HALFW-1:0]        heading_half_o,
  output logic [$clog2(SAMPLES+1)-1:0]      win_count_o
);

  localparam int unsigned CNTW  = $clog2(SAMPLES + 1);
  localparam int unsigned RSH   = chav_pkg::SUMW + $clog2(SAMPLES);
  localparam int unsigned RW    = RSH + 1;
  localparam int unsigned RECIP = ((2 ** RSH) + SAMPLES - 1) / SAMPLES;
  localparam int unsigned PADW  = chav_pkg::CW - chav_pkg::SW - chav_pkg::FRACW;

  logic adv;

  chav_pkg::cordic_t          c_q [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]      vld_q;

  logic signed [chav_pkg::CW-1:0] xe, ye;
  chav_pkg::cordic_t              prep;

  logic signed [chav_pkg::ZW-1:0] zw;
  logic [chav_pkg::DW-1:0]        deg_raw, deg;
  logic                           h_vld_q;
  logic [chav_pkg::DW-1:0]        h_deg_q;

  logic [CNTW-1:0]            cnt_q, cnt_n;
  logic [chav_pkg::SUMW-1:0]  sum_q, sum_n;
  logic                       w_vld_q;
  logic [chav_pkg::SUMW-1:0]  w_sum_q;

  logic [chav_pkg::SUMW+RW-1:0] mean_prod;
  logic                         out_vld_q;
  logic [chav_pkg::MEANW-1:0]   out_mean_q;

  // The whole back pipeline moves together unless a result waits.
  assign adv   = !out_vld_q || out_ready_i;
  assign pop_o = adv && !q_status_i.empty;

  // Scale to 16 fraction bits; fold the left half plane onto the right.
  assign xe = {{PADW{pop_data_i.sx[chav_pkg::SW-1]}}, pop_data_i.sx, {chav_pkg::FRACW{1'b0}}};
  assign ye = {{PADW{pop_data_i.sy[chav_pkg::SW-1]}}, pop_data_i.sy, {chav_pkg::FRACW{1'b0}}};

  always_comb begin
    if (xe[chav_pkg::CW-1]) begin
      prep.x = chav_pkg::CW'(0) - xe;
      prep.y = chav_pkg::CW'(0) - ye;
      prep.z = chav_pkg::ZHALF;
    end else begin
      prep.x = xe;
      prep.y = ye;
      prep.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q[0] <= prep;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    localparam logic signed [chav_pkg::ZW-1:0] ANG = chav_pkg::atan_deg(g);

    logic signed [chav_pkg::CW-1:0] xi, yi, dx, dy;
    logic signed [chav_pkg::ZW-1:0] zi;
    chav_pkg::cordic_t              nx;

    assign xi = c_q[g].x;
    assign yi = c_q[g].y;
    assign zi = c_q[g].z;
    assign dx = yi >>> g;
    assign dy = xi >>> g;

    // A zero residual holds the vector and the angle.
    always_comb begin
      nx = c_q[g];
      if (yi[chav_pkg::CW-1]) begin
        nx.x = xi - dx;
        nx.y = yi + dy;
        nx.z = zi - ANG;
      end else if (yi != '0) begin
        nx.x = xi + dx;
        nx.y = yi - dy;
        nx.z = zi + ANG;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (adv) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        c_q[g+1] <= nx;
      end
    end
  end

  // Wrap into 0..359 whole degrees.
  assign zw      = c_q[CORDIC_STEPS].z[chav_pkg::ZW-1] ?
                   (c_q[CORDIC_STEPS].z + chav_pkg::ZFULL) : c_q[CORDIC_STEPS].z;
  assign deg_raw = zw[chav_pkg::FRACW +: chav_pkg::DW];
  assign deg     = (deg_raw >= chav_pkg::FULL_TURN) ? (deg_raw - chav_pkg::FULL_TURN)
                                                    : deg_raw;

  assign cnt_n = cnt_q + CNTW'(1);
  assign sum_n = sum_q + chav_pkg::SUMW'(h_deg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q   <= 1'b0;
      cnt_q     <= '0;
      sum_q     <= '0;
      w_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      h_vld_q   <= vld_q[CORDIC_STEPS];
      out_vld_q <= w_vld_q;
      w_vld_q   <= 1'b0;
      if (h_vld_q) begin
        if (cnt_n == CNTW'(SAMPLES)) begin
          cnt_q   <= '0;
          sum_q   <= '0;
          w_vld_q <= 1'b1;
        end else begin
          cnt_q <= cnt_n;
          sum_q <= sum_n;
        end
      end
    end
  end

  // Divide by the window length through a reciprocal that is exact for
  // every 15 bit sum.
  assign mean_prod = {{RW{1'b0}}, w_sum_q} * {{chav_pkg::SUMW{1'b0}}, RW'(RECIP)};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_deg_q    <= deg;
      w_sum_q    <= sum_n;
      out_mean_q <= mean_prod[RSH +: chav_pkg::MEANW];
    end
  end

  assign out_valid_o    = out_vld_q;
  assign heading_mean_o = out_mean_q;
  assign heading_half_o = out_mean_q[chav_pkg::MEANW-1:1];
  assign win_count_o    = cnt_q;

endmodule

`default_nettype wire

### sv/compass_heading_averager_top.sv
// Throughput: one item per cycle, set by the fully pipelined CORDIC with one stage per iteration,
// as long as no finished result waits to be taken.
// Zero-X items are dropped in the front.
// Reset (rst_ni low, asynchronous) empties the pipeline and queue, clears the window
// count and sum, and loads the registers with x_offset 15, y_offset 85, axis_gain 60293.
`default_nettype none

module compass_heading_averager_top #(
  parameter int unsigned SAMPLES      = chav_pkg::SAMPLES_DEF,
  parameter int unsigned CORDIC_STEPS = chav_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [chav_pkg::IDXW-1:0]          cfg_idx_i,
  input  wire logic [chav_pkg::CFGW-1:0]          cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [chav_pkg::RAWW-1:0]   x_raw_i,
  input  wire logic signed [chav_pkg::RAWW-1:0]   y_raw_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [chav_pkg::MEANW-1:0]              heading_mean_o,
  output logic [chav_pkg::HALFW-1:0]              heading_half_o
);

  // The front holds the configuration registers, adds the hard-iron offsets,
  // applies the gain and drops every item whose scaled X is zero. Surviving
  // items wait in a short queue, so the front keeps taking items while the
  // back is held by a result that has not been taken yet, until the queue fills.
  logic                          q_push, q_pop;
  chav_pkg::axis_t               q_wdata, q_rdata;
  chav_pkg::q_status_t           q_status;
  logic [$clog2(SAMPLES+1)-1:0]  win_count;

  chav_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .x_raw_i     (x_raw_i),
    .y_raw_i     (y_raw_i),
    .q_status_i  (q_status),
    .push_o      (q_push),
    .push_data_o (q_wdata)
  );

  chav_fifo #(
    .DEPTH (chav_pkg::QDEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .status_o    (q_status)
  );

  // The back runs the vectoring CORDIC, wraps the angle to whole degrees,
  // accumulates the window and divides the sum by the window length. The
  // finished mean sits in an output register until it is taken.
  chav_back #(
    .SAMPLES      (SAMPLES),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .pop_data_i     (q_rdata),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .heading_mean_o (heading_mean_o),
    .heading_half_o (heading_half_o),
    .win_count_o    (win_count)
  );

  // The front must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_status.full))
    else $error("queue push while full");

  // The back must never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_status.empty))
    else $error("queue pop while empty");

  // The window count wraps to zero when the window closes.
  a_win_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_count < ($clog2(SAMPLES+1))'(SAMPLES))
    else $error("window count reached the window length");

  // A mean of whole-degree headings stays below a full turn.
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_mean_o < chav_pkg::FULL_TURN))
    else $error("heading mean out of range");

endmodule

`default_nettype wire
